// ----- rtl/gcr_pkg.sv -----
// Shared types and constants for the grid column raycaster.
package gcr_pkg;

    // Default geometry
    localparam int MAP_COLS_DEF    = 16;
    localparam int MAP_ROWS_DEF    = 16;
    localparam int SCREEN_COLS_DEF = 128;
    localparam int SCREEN_ROWS_DEF = 64;

    // Stored map is 16 x 16 tiles
    localparam int TILE_W  = 4;
    localparam int CODE_W  = 4;
    localparam int CELL_W  = 8;

    // Datapath widths
    localparam int CAM_W   = 20;
    localparam int RAY_W   = 24;
    localparam int SD_W    = 48;
    localparam int NUM_W   = 31;
    localparam int DEN_W   = 48;
    localparam int FRAC_W  = 13;

    localparam logic [SD_W-1:0] DELTA_INF = 48'h0100_0000_0000;
    localparam logic [NUM_W-1:0] DELTA_NUM = 31'h4000_0000;
    localparam logic [SD_W-1:0] DIST_EPS  = 48'd7;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_VOFF    = 3'd6;

    typedef enum logic [1:0] {
        DIV_DX,
        DIV_DY,
        DIV_LH
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM,
        S_RAY_X,
        S_RAY_Y,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_SIDE_X,
        S_SIDE_Y,
        S_STEP,
        S_CHECK,
        S_LH_GO,
        S_LH_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     load_column;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_cam;
        logic     ray_mul;
        logic     ray_y;
        logic     load_delta;
        logic     delta_y;
        logic     side_init;
        logic     side_y;
        logic     step;
        logic     check;
        logic     load_lh;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic stop;
    } dp_status_t;

endpackage

// ----- rtl/gcr_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module gcr_divider #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

// ----- rtl/gcr_tile_map.sv -----
// Tile map storage with per-entry valid bits so reset reads as empty.
module gcr_tile_map
    import gcr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [2*gcr_pkg::TILE_W-1:0] waddr,
    input  logic [gcr_pkg::CODE_W-1:0]   wdata,
    input  logic                       re,
    input  logic [2*gcr_pkg::TILE_W-1:0] raddr,
    output logic [gcr_pkg::CODE_W-1:0]   rdata
);
    localparam int DEPTH = 1 << (2 * TILE_W);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [CODE_W-1:0] rd_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

// ----- rtl/gcr_datapath.sv -----
// Raycaster datapath: registers, ray setup, DDA walk and span math.
module gcr_datapath
    import gcr_pkg::*;
#(
    parameter int MAP_COLS    = gcr_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = gcr_pkg::MAP_ROWS_DEF,
    parameter int SCREEN_COLS = gcr_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = gcr_pkg::SCREEN_ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 tile_we,
    input  logic [3:0]           tile_x,
    input  logic [3:0]           tile_y,
    input  logic [3:0]           tile_code,
    input  logic [6:0]           column,
    input  gcr_pkg::dp_cmd_t     cmd,
    output gcr_pkg::dp_status_t  status,
    output logic [15:0]          wall_distance,
    output logic [3:0]           hit_code,
    output logic                 hit_side,
    output logic signed [5:0]    hit_cell_x,
    output logic signed [5:0]    hit_cell_y,
    output logic [11:0]          line_height,
    output logic [5:0]           draw_top,
    output logic [5:0]           draw_bottom
);
    localparam int WALK_LIMIT = MAP_COLS + MAP_ROWS + 40;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam int LH_NUM     = SCREEN_ROWS * 65536;
    localparam int SPAN_W     = 14;

    // Configuration
    logic [15:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic signed [4:0]  voff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 16'd6144;
            pos_y_reg   <= 16'd6144;
            dir_x_reg   <= 16'sd16384;
            dir_y_reg   <= 16'sd0;
            plane_x_reg <= 16'sd0;
            plane_y_reg <= 16'sd10813;
            voff_reg    <= 5'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_DIR_X:   dir_x_reg   <= cfg_data;
                REG_DIR_Y:   dir_y_reg   <= cfg_data;
                REG_PLANE_X: plane_x_reg <= cfg_data;
                REG_PLANE_Y: plane_y_reg <= cfg_data;
                REG_VOFF:    voff_reg    <= cfg_data[4:0];
                default:     ;
            endcase
        end
    end

    // Working registers
    logic [6:0]               col_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [SD_W-1:0]          dx_reg, dy_reg, sdx_reg, sdy_reg;
    logic                     dx_inf_reg, dy_inf_reg;
    logic signed [CELL_W-1:0] mx_reg, my_reg;
    logic                     side_reg;
    logic                     outside_reg, beyond_reg;
    logic [STEP_W-1:0]        steps_reg;
    logic [CODE_W-1:0]        code_reg;
    logic [11:0]              lh_reg;

    // Divider
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [RAY_W-1:0] rx_mag, ry_mag;
    logic [SD_W-1:0]  perp_dist;

    assign rx_mag    = rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign ry_mag    = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
    assign perp_dist = side_reg ? (sdy_reg - dy_reg) : (sdx_reg - dx_reg);

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DX:
            begin
                div_num = DELTA_NUM;
                div_den = DEN_W'(rx_mag);
            end
            DIV_DY:
            begin
                div_num = DELTA_NUM;
                div_den = DEN_W'(ry_mag);
            end
            DIV_LH:
            begin
                div_num = NUM_W'(LH_NUM);
                div_den = perp_dist + DIST_EPS;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    gcr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Camera offset table: column * 2^15 / SCREEN_COLS
    logic [CAM_W-1:0] cam_q;

    always_comb
    begin
        cam_q = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (col_reg == 7'(i))
            begin
                cam_q = CAM_W'((i * 32768) / SCREEN_COLS);
            end
        end
    end

    // Ray multiplier: ray = dir + plane * cam / 2^14
    logic signed [15:0]         mul_plane, mul_dir;
    logic signed [CAM_W+15:0]   ray_prod;
    logic signed [RAY_W-1:0]    ray_sum;

    assign mul_plane = cmd.ray_y ? plane_y_reg : plane_x_reg;
    assign mul_dir   = cmd.ray_y ? dir_y_reg : dir_x_reg;
    assign ray_prod  = mul_plane * cam_reg;
    assign ray_sum   = RAY_W'(mul_dir) + RAY_W'(ray_prod >>> 14);

    // Initial side distance multiplier
    logic [FRAC_W-1:0]  fx, fy, side_f;
    logic [SD_W-1:0]    side_d;
    logic               side_inf;
    logic [FRAC_W+30:0] side_prod;
    logic [SD_W-1:0]    side_val;

    assign fx = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[11:0]}
                                : FRAC_W'(13'd4096 - {1'b0, pos_x_reg[11:0]});
    assign fy = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[11:0]}
                                : FRAC_W'(13'd4096 - {1'b0, pos_y_reg[11:0]});
    assign side_f    = cmd.side_y ? fy : fx;
    assign side_d    = cmd.side_y ? dy_reg : dx_reg;
    assign side_inf  = cmd.side_y ? dy_inf_reg : dx_inf_reg;
    assign side_prod = side_f * side_d[30:0];
    assign side_val  = side_inf ? (SD_W'(side_f) << 28) : SD_W'(side_prod >> 12);

    // DDA step
    logic                     x_go;
    logic signed [CELL_W-1:0] mx_next, my_next, cx, cy;
    logic                     cell_out, cell_beyond;
    logic [2*TILE_W-1:0]      map_raddr;
    logic [CODE_W-1:0]        map_rdata;
    logic [CODE_W-1:0]        code_now;

    assign x_go    = sdx_reg < sdy_reg;
    assign mx_next = rx_reg[RAY_W-1] ? CELL_W'(mx_reg - CELL_W'(1))
                                     : CELL_W'(mx_reg + CELL_W'(1));
    assign my_next = ry_reg[RAY_W-1] ? CELL_W'(my_reg - CELL_W'(1))
                                     : CELL_W'(my_reg + CELL_W'(1));
    assign cx      = x_go ? mx_next : mx_reg;
    assign cy      = x_go ? my_reg : my_next;
    assign cell_out = cx[CELL_W-1] || (cx >= CELL_W'(MAP_COLS))
                   || cy[CELL_W-1] || (cy >= CELL_W'(MAP_ROWS));
    assign cell_beyond = (cx >= CELL_W'(16)) || (cy >= CELL_W'(16));
    assign map_raddr   = {cy[TILE_W-1:0], cx[TILE_W-1:0]};

    gcr_tile_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tile_we),
        .waddr ({tile_y, tile_x}),
        .wdata (tile_code),
        .re    (cmd.step),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign code_now = outside_reg ? CODE_W'(1) : (beyond_reg ? '0 : map_rdata);
    assign status.stop = outside_reg || (code_now != '0)
                      || (steps_reg == STEP_W'(WALK_LIMIT));
    assign status.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load_column)
        begin
            col_reg <= column;
        end
        if (cmd.load_cam)
        begin
            cam_reg <= $signed(cam_q) - CAM_W'(16384);
        end
        if (cmd.ray_mul)
        begin
            if (cmd.ray_y)
            begin
                ry_reg <= ray_sum;
            end
            else
            begin
                rx_reg <= ray_sum;
            end
        end
        if (cmd.load_delta)
        begin
            if (cmd.delta_y)
            begin
                dy_reg     <= (ry_reg == '0) ? DELTA_INF : SD_W'(div_quo);
                dy_inf_reg <= ry_reg == '0;
            end
            else
            begin
                dx_reg     <= (rx_reg == '0) ? DELTA_INF : SD_W'(div_quo);
                dx_inf_reg <= rx_reg == '0;
            end
        end
        if (cmd.side_init)
        begin
            if (cmd.side_y)
            begin
                sdy_reg <= side_val;
            end
            else
            begin
                sdx_reg   <= side_val;
                mx_reg    <= CELL_W'(pos_x_reg[15:12]);
                my_reg    <= CELL_W'(pos_y_reg[15:12]);
                steps_reg <= '0;
                side_reg  <= 1'b0;
            end
        end
        if (cmd.step)
        begin
            if (x_go)
            begin
                sdx_reg  <= sdx_reg + dx_reg;
                mx_reg   <= mx_next;
                side_reg <= 1'b0;
            end
            else
            begin
                sdy_reg  <= sdy_reg + dy_reg;
                my_reg   <= my_next;
                side_reg <= 1'b1;
            end
            outside_reg <= cell_out;
            beyond_reg  <= cell_beyond;
            steps_reg   <= steps_reg + 1'b1;
        end
        if (cmd.check)
        begin
            code_reg <= (code_now == '0) ? CODE_W'(1) : code_now;
        end
        if (cmd.load_lh)
        begin
            lh_reg <= (div_quo[NUM_W-1:12] != '0) ? 12'hFFF : div_quo[11:0];
        end
    end

    // Wall span
    logic signed [SPAN_W-1:0] center, half, top_s, bot_s;
    logic [5:0]               top_c, bot_c;

    assign center = SPAN_W'(SCREEN_ROWS / 2) + SPAN_W'(voff_reg);
    assign half   = $signed({3'b0, lh_reg[11:1]});
    assign top_s  = center - half;
    assign bot_s  = center + half;

    always_comb
    begin
        if (top_s < 0)
        begin
            top_c = '0;
        end
        else if (top_s > SPAN_W'(SCREEN_ROWS - 1))
        begin
            top_c = 6'(SCREEN_ROWS - 1);
        end
        else
        begin
            top_c = top_s[5:0];
        end
        if (bot_s < 0)
        begin
            bot_c = '0;
        end
        else if (bot_s > SPAN_W'(SCREEN_ROWS - 1))
        begin
            bot_c = 6'(SCREEN_ROWS - 1);
        end
        else
        begin
            bot_c = bot_s[5:0];
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            wall_distance <= (perp_dist[SD_W-1:22] != '0) ? 16'hFFFF : perp_dist[21:6];
            hit_code      <= code_reg;
            hit_side      <= side_reg;
            hit_cell_x    <= mx_reg[5:0];
            hit_cell_y    <= my_reg[5:0];
            line_height   <= lh_reg;
            draw_top      <= top_c;
            draw_bottom   <= bot_c;
        end
    end

    // A step moves exactly one axis
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (side_reg ? (mx_reg == $past(mx_reg)) : (my_reg == $past(my_reg))))
        else $error("DDA step moved both axes");

endmodule

// ----- rtl/gcr_ctrl.sv -----
// Raycaster sequencer: drives the datapath through setup, walk and output.
module gcr_ctrl
    import gcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                command,
    output logic                cmd_stall,
    output logic                res_valid,
    input  logic                res_stall,
    input  gcr_pkg::dp_status_t status,
    output gcr_pkg::dp_cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_DX;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && command == CMD_CAST)
                begin
                    cmd.load_column = 1'b1;
                    state_next      = S_CAM;
                end
            end
            S_CAM:
            begin
                cmd.load_cam = 1'b1;
                state_next   = S_RAY_X;
            end
            S_RAY_X:
            begin
                cmd.ray_mul = 1'b1;
                state_next  = S_RAY_Y;
            end
            S_RAY_Y:
            begin
                cmd.ray_mul = 1'b1;
                cmd.ray_y   = 1'b1;
                state_next  = S_DX_GO;
            end
            S_DX_GO:
            begin
                cmd.div_sel   = DIV_DX;
                cmd.div_start = 1'b1;
                state_next    = S_DX_WAIT;
            end
            S_DX_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_delta = 1'b1;
                    state_next     = S_DY_GO;
                end
            end
            S_DY_GO:
            begin
                cmd.div_sel   = DIV_DY;
                cmd.div_start = 1'b1;
                state_next    = S_DY_WAIT;
            end
            S_DY_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_delta = 1'b1;
                    cmd.delta_y    = 1'b1;
                    state_next     = S_SIDE_X;
                end
            end
            S_SIDE_X:
            begin
                cmd.side_init = 1'b1;
                state_next    = S_SIDE_Y;
            end
            S_SIDE_Y:
            begin
                cmd.side_init = 1'b1;
                cmd.side_y    = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.stop ? S_LH_GO : S_STEP;
            end
            S_LH_GO:
            begin
                cmd.div_sel   = DIV_LH;
                cmd.div_start = 1'b1;
                state_next    = S_LH_WAIT;
            end
            S_LH_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_lh = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign cmd_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;

    // Never overwrite a word still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!res_valid_reg || !res_stall))
        else $error("result overwritten while stalled");

    // A cast leaves idle and reaches the ray setup
    a_cast_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && command == CMD_CAST) |=> state_reg == S_CAM)
        else $error("cast not started");

    // Walk returns to step until it stops
    a_walk_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !status.stop) |=> state_reg == S_STEP)
        else $error("walk left early");

endmodule

// ----- rtl/grid_column_raycaster.sv -----
// Grid column raycaster top level.
// Write words (command 0) store one tile and are taken whenever the block is idle.
// A cast word (command 1) runs one ray: the camera offset comes from a constant
// table, two multiplies form the ray, two divisions on a shared restoring
// divider give the x and y step lengths (each: start, 31 quotient bits,
// done), two multiplies give the initial side distances, then the DDA walk
// takes each tile step as a map read then a hit test, then a third division
// gives the line height. The walk stops after at most MAP_COLS + MAP_ROWS + 40
// tile steps if no hit comes first, and the result word waits for a stalled
// result to leave. No word is taken during a cast.
// The result sits in an output register, so a new word is taken while it
// waits. The map reads as empty after reset; no clearing pass is needed.
module grid_column_raycaster #(
    parameter int MAP_COLS    = gcr_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = gcr_pkg::MAP_ROWS_DEF,
    parameter int SCREEN_COLS = gcr_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = gcr_pkg::SCREEN_ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic              command,
    input  logic [3:0]        tile_x,
    input  logic [3:0]        tile_y,
    input  logic [3:0]        tile_code,
    input  logic [6:0]        column,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [15:0]       wall_distance,
    output logic [3:0]        hit_code,
    output logic              hit_side,
    output logic signed [5:0] hit_cell_x,
    output logic signed [5:0] hit_cell_y,
    output logic [11:0]       line_height,
    output logic [5:0]        draw_top,
    output logic [5:0]        draw_bottom
);
    import gcr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       tile_we;

    assign tile_we = cmd_valid && !cmd_stall && command == CMD_WRITE;

    gcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (command),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gcr_datapath #(
        .MAP_COLS    (MAP_COLS),
        .MAP_ROWS    (MAP_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tile_we       (tile_we),
        .tile_x        (tile_x),
        .tile_y        (tile_y),
        .tile_code     (tile_code),
        .column        (column),
        .cmd           (cmd),
        .status        (status),
        .wall_distance (wall_distance),
        .hit_code      (hit_code),
        .hit_side      (hit_side),
        .hit_cell_x    (hit_cell_x),
        .hit_cell_y    (hit_cell_y),
        .line_height   (line_height),
        .draw_top      (draw_top),
        .draw_bottom   (draw_bottom)
    );

endmodule

// ----- test/gcr_checker.sv -----
// Checker for the grid column raycaster: mirrors the map and registers, predicts and compares.
module gcr_checker
    import gcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  logic              command,
    input  logic [3:0]        tile_x,
    input  logic [3:0]        tile_y,
    input  logic [3:0]        tile_code,
    input  logic [6:0]        column,
    input  logic              res_valid,
    input  logic              res_stall,
    input  logic [15:0]       wall_distance,
    input  logic [3:0]        hit_code,
    input  logic              hit_side,
    input  logic signed [5:0] hit_cell_x,
    input  logic signed [5:0] hit_cell_y,
    input  logic [11:0]       line_height,
    input  logic [5:0]        draw_top,
    input  logic [5:0]        draw_bottom,
    output int                errors,
    output int                pending
);

    localparam int SCR_COLS  = SCREEN_COLS_DEF;
    localparam int SCR_ROWS  = SCREEN_ROWS_DEF;
    localparam int WALK_MAX  = MAP_COLS_DEF + MAP_ROWS_DEF + 40;

    typedef struct packed {
        logic [15:0] wd;
        logic [3:0]  code;
        logic        side;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [11:0] lh;
        logic [5:0]  top;
        logic [5:0]  bot;
    } column_hit_t;

    logic [3:0]  map_copy [256];
    logic [15:0] view_x, view_y;
    longint      look_x, look_y, cam_px, cam_py, row_shift;
    column_hit_t hits_due [$];

    assign pending = hits_due.size();

    function automatic longint unsigned step_len(input longint r);
        if (r == 0)
            return 64'd1 << 40;
        return (64'd1 << 30) / longint'(r < 0 ? -r : r);
    endfunction

    function automatic column_hit_t cast_column(input logic [6:0] col);
        longint cam, rx, ry, mx, my, top, bot, half, stx, sty;
        longint unsigned dx, dy, sdx, sdy, fx, fy, perp, wd, lh;
        logic [3:0] code;
        bit side, outside;
        column_hit_t h;
        code = 4'd1;
        side = 0;
        outside = 0;
        cam = (longint'(col) * 2 * 16384) / SCR_COLS - 16384;
        rx = look_x + ((cam_px * cam) >>> 14);
        ry = look_y + ((cam_py * cam) >>> 14);
        mx = view_x >> 12;
        my = view_y >> 12;
        dx = step_len(rx);
        dy = step_len(ry);
        fx = view_x[11:0];
        fy = view_y[11:0];
        if (rx < 0) stx = -1; else begin stx = 1; fx = 4096 - fx; end
        if (ry < 0) sty = -1; else begin sty = 1; fy = 4096 - fy; end
        sdx = (fx * dx) >> 12;
        sdy = (fy * dy) >> 12;
        for (int i = 0; i < WALK_MAX; i++)
        begin
            if (sdx < sdy)
            begin
                sdx += dx;
                mx += stx;
                side = 0;
            end
            else
            begin
                sdy += dy;
                my += sty;
                side = 1;
            end
            outside = mx < 0 || mx >= MAP_COLS_DEF || my < 0 || my >= MAP_ROWS_DEF;
            code = outside ? 4'd1 : map_copy[my * 16 + mx];
            if (outside || code != 0)
                break;
        end
        if (!outside && code == 0)
            code = 4'd1;
        perp = side ? sdy - dy : sdx - dx;
        wd = perp >> 6;
        if (wd > 65535) wd = 65535;
        lh = (longint'(SCR_ROWS) << 16) / (perp + 7);
        if (lh > 4095) lh = 4095;
        half = lh / 2;
        top = SCR_ROWS / 2 + row_shift - half;
        bot = SCR_ROWS / 2 + row_shift + half;
        if (top < 0) top = 0;
        if (top > SCR_ROWS - 1) top = SCR_ROWS - 1;
        if (bot < 0) bot = 0;
        if (bot > SCR_ROWS - 1) bot = SCR_ROWS - 1;
        h.wd   = wd[15:0];
        h.code = code;
        h.side = side;
        h.cx   = mx[5:0];
        h.cy   = my[5:0];
        h.lh   = lh[11:0];
        h.top  = top[5:0];
        h.bot  = bot[5:0];
        return h;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        column_hit_t want, got;
        if (!rst_n)
        begin
            foreach (map_copy[i]) map_copy[i] = '0;
            view_x = 16'd6144;
            view_y = 16'd6144;
            look_x = 16384;
            look_y = 0;
            cam_px = 0;
            cam_py = 10813;
            row_shift = 0;
            errors = 0;
            hits_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POS_X:   view_x = cfg_data;
                    REG_POS_Y:   view_y = cfg_data;
                    REG_DIR_X:   look_x = longint'($signed(cfg_data));
                    REG_DIR_Y:   look_y = longint'($signed(cfg_data));
                    REG_PLANE_X: cam_px = longint'($signed(cfg_data));
                    REG_PLANE_Y: cam_py = longint'($signed(cfg_data));
                    REG_VOFF:    row_shift = longint'($signed(cfg_data[4:0]));
                    default: ;
                endcase
            end
            if (res_valid && !res_stall)
            begin
                got = {wall_distance, hit_code, hit_side, hit_cell_x, hit_cell_y,
                       line_height, draw_top, draw_bottom};
                if (hits_due.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (want != got)
                    begin
                        $display({"%0t: mismatch exp wd=%0d code=%0d side=%0d",
                                  " cell=(%0d,%0d) lh=%0d top=%0d bot=%0d"},
                                 $time, want.wd, want.code, want.side, $signed(want.cx),
                                 $signed(want.cy), want.lh, want.top, want.bot);
                        $display({"%0t:          got wd=%0d code=%0d side=%0d",
                                  " cell=(%0d,%0d) lh=%0d top=%0d bot=%0d"},
                                 $time, got.wd, got.code, got.side, $signed(got.cx),
                                 $signed(got.cy), got.lh, got.top, got.bot);
                        errors++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (command == CMD_WRITE)
                    map_copy[{tile_y, tile_x}] = tile_code;
                else
                    hits_due.push_back(cast_column(column));
            end
        end
    end

endmodule

// ----- test/grid_column_raycaster_tb.sv -----
// Testbench top for the grid column raycaster: stimulus, idling, watchdog and verdict.
module grid_column_raycaster_tb;
    import gcr_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int STALL_LIMIT = 20000;

    logic clk, rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic cmd_valid, cmd_stall, command;
    logic [3:0] tile_x, tile_y, tile_code;
    logic [6:0] column;
    logic res_valid, res_stall;
    logic [15:0] wall_distance;
    logic [3:0] hit_code;
    logic hit_side;
    logic signed [5:0] hit_cell_x, hit_cell_y;
    logic [11:0] line_height;
    logic [5:0] draw_top, draw_bottom;
    int errors, pending;
    int send_idle_pct, recv_idle_pct;
    bit hold_req;
    bit hold_done;
    int quiet_cycles;

    grid_column_raycaster u_dut (.*);

    gcr_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stall, or one long hold when asked
    initial
    begin
        res_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                repeat (2000)
                begin
                    res_stall = 1;
                    @(negedge clk);
                end
            end
            res_stall = $urandom_range(99) < recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic send_word(input logic cmd, input logic [3:0] tx, input logic [3:0] ty,
                             input logic [3:0] tc, input logic [6:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 0;
            @(negedge clk);
        end
        cmd_valid = 1;
        command = cmd;
        tile_x = tx;
        tile_y = ty;
        tile_code = tc;
        column = col;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
    endtask

    task automatic cast(input logic [6:0] col);
        send_word(CMD_CAST, 4'($urandom), 4'($urandom), 4'($urandom), col);
    endtask

    task automatic put_tile(input logic [3:0] tx, input logic [3:0] ty, input logic [3:0] tc);
        send_word(CMD_WRITE, tx, ty, tc, 7'($urandom));
    endtask

    // hold the sender until every result is back
    task automatic drain();
        cmd_valid = 0;
        wait (pending == 0);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_view(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] plx, input logic [15:0] ply,
                            input logic [15:0] vo);
        reg_write(REG_POS_X, px);
        reg_write(REG_POS_Y, py);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
        reg_write(REG_PLANE_X, plx);
        reg_write(REG_PLANE_Y, ply);
        reg_write(REG_VOFF, vo);
    endtask

    task automatic random_view();
        int dx, dy;
        dx = $urandom_range(32768) - 16384;
        dy = $urandom_range(32768) - 16384;
        set_view(16'($urandom_range(4096 * 15 - 1, 4096)),
                 16'($urandom_range(4096 * 15 - 1, 4096)),
                 16'(dx), 16'(dy), 16'(-(dy * 2) / 3), 16'((dx * 2) / 3),
                 16'($urandom_range(16) - 8));
    endtask

    task automatic random_word();
        if ($urandom_range(99) < 30)
            put_tile(4'($urandom), 4'($urandom),
                     $urandom_range(99) < 50 ? 4'd0 : 4'($urandom));
        else
            cast(7'($urandom));
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_valid = 0;
        command = CMD_WRITE;
        tile_x = '0;
        tile_y = '0;
        tile_code = '0;
        column = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // empty map: rays leave the map; middle column has a zero y component
        cast(7'd0);
        cast(7'd64);
        cast(7'd127);
        put_tile(4'd3, 4'd1, 4'd15);
        put_tile(4'd1, 4'd3, 4'd7);
        put_tile(4'd15, 4'd15, 4'd15);
        put_tile(4'd0, 4'd0, 4'd1);
        cast(7'd64);
        cast(7'd0);
        cast(7'd127);
        put_tile(4'd3, 4'd1, 4'd0);
        cast(7'd64);
        drain();

        // extreme settings
        set_view(16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFF8);
        reg_write(REG_SPARE, 16'hFFFF);
        cast(7'd0);
        cast(7'd127);
        cast(7'd64);
        drain();
        set_view(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd8);
        cast(7'd0);
        cast(7'd127);
        cast(7'd85);
        drain();
        set_view(16'h1000, 16'h1000, 16'h4000, 16'h0000, 16'h0000, 16'h2A3D, 16'd0);
        cast(7'd64);
        cast(7'd0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = ph == 0 ? 25 : ph == 1 ? 61 : 0;
            recv_idle_pct = ph == 0 ? 61 : ph == 1 ? 25 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                random_view();
                if (ph == 2 && blk == 1)
                    hold_req = 1;
                repeat (108) random_word();
                drain();
            end
        end

        drain();
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
